FILE: rtl/core/ordered_array_table_engine_unit_defines.svh
// Assertion macros for the ordered array table engine
`ifndef ORDERED_ARRAY_TABLE_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_ARRAY_TABLE_ENGINE_UNIT_DEFINES_SVH

// property that must hold whenever reset is low
`define OATE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define OATE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/oate_pkg.sv
// ----------------------------------------------------------------------------
// oate_pkg
// Types and constants shared by the ordered array table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package oate_pkg;
   localparam int DEPTH_DEF = 64;
   localparam int CAP_W     = 7;
   localparam int WORD_W    = 32;
   localparam int TOTAL_W   = 39;
   localparam int IDX_W     = 6;

   localparam logic [2:0] MODE_APPEND = 3'd0;
   localparam logic [2:0] MODE_INSERT = 3'd1;
   localparam logic [2:0] MODE_DELETE = 3'd2;
   localparam logic [2:0] MODE_LSRCH  = 3'd3;
   localparam logic [2:0] MODE_BSRCH  = 3'd4;
   localparam logic [2:0] MODE_STATS  = 3'd5;

   localparam logic signed [WORD_W-1:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_LS,
      ST_BS_RD,
      ST_BS_CMP,
      ST_STAT,
      ST_DIV,
      ST_OUT
   } state_type;

   // result payload, tdata packing order highest first
   typedef struct packed {
      logic [CAP_W-1:0]          fill_count;
      logic signed [WORD_W-1:0]  smallest;
      logic signed [WORD_W-1:0]  largest;
      logic signed [WORD_W-1:0]  average;
      logic signed [TOTAL_W-1:0] total;
      logic signed [WORD_W-1:0]  removed_value;
      logic [IDX_W-1:0]          found_index;
      logic                      ok;
   } result_type;
endpackage
`default_nettype wire

FILE: rtl/core/ordered_array_table_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_array_table_engine_unit
// Packed word store with append, insert, delete, searches and statistics.
// ----------------------------------------------------------------------------
// One transaction at a time. Words live in a single-port-write, registered-read
// memory of DEPTH entries; every walk touches one entry per cycle unless a linear
// search is held by a stalled result. Statistics ends with a restoring division
// for the average. Linear search returns one result per match, the last flagged
// with tlast, or a single miss result when nothing matches. Results wait in an
// output register; the next transaction is taken once the current one is
// delivered.
`timescale 1ns / 1ps
`default_nettype none
module ordered_array_table_engine_unit #(
   parameter int DEPTH = oate_pkg::DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [6:0]           csr_wdata,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // mode[2:0], position[9:3], data[41:10], zero fill to 48
   input  wire logic [47:0]          req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // ok[0], found_index[6:1], removed_value[38:7], total[77:39],
   // average[109:78], largest[141:110], smallest[173:142], fill_count[180:174]
   output logic [183:0]              rsp_tdata,
   output logic                      rsp_tlast
);
   import oate_pkg::*;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic [AW-1:0]            raddr, waddr;
   logic                     we;
   logic signed [WORD_W-1:0] wdata, rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   state_type state_ff, state_in;
   logic [6:0]  cap_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]  mode_ff, mode_in;
   logic [6:0]  pos_ff, pos_in;
   logic signed [WORD_W-1:0] key_ff, key_in, hold_ff, hold_in;
   logic [CW:0] i_ff, i_in;               // walk index
   logic signed [CW:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0] mid_ff, mid_in;
   logic signed [TOTAL_W-1:0] sum_ff, sum_in;
   logic signed [WORD_W-1:0] big_ff, big_in, sml_ff, sml_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [TOTAL_W-1:0] quo_ff, quo_in, rem_ff, rem_in;
   logic        neg_ff, neg_in, any_ff, any_in, pend_ff, pend_in;
   logic [AW-1:0] pidx_ff, pidx_in;       // held match in linear search
   result_type res_ff, res_in;
   logic        ov_ff, ov_in, olast_ff, olast_in;

   logic [CW-1:0] cap_eff;
   logic          fits;
   logic [TOTAL_W-1:0] mag, trial;
   logic [TOTAL_W:0]   rsh;
   result_type r0;

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= 7'd64;
      else if (csr_we) cap_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
      end
      mode_ff <= mode_in; pos_ff <= pos_in; key_ff <= key_in; hold_ff <= hold_in;
      i_ff <= i_in; lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in;
      sum_ff <= sum_in; big_ff <= big_in; sml_ff <= sml_in; dcnt_ff <= dcnt_in;
      quo_ff <= quo_in; rem_ff <= rem_in; neg_ff <= neg_in; any_ff <= any_in;
      pend_ff <= pend_in; pidx_ff <= pidx_in; res_ff <= res_in; olast_ff <= olast_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {3'b000, res_ff};
   assign rsp_tlast  = olast_ff;
   assign req_tready = (state_ff == ST_IDLE) && !ov_ff;

   always_comb begin
      cap_eff = (cap_ff > 7'(DEPTH)) ? CW'(DEPTH) : CW'(cap_ff);
      fits    = count_ff < cap_eff;
      mag     = sum_ff[TOTAL_W-1] ? TOTAL_W'(-sum_ff) : TOTAL_W'(sum_ff);
      rsh     = {rem_ff, quo_ff[TOTAL_W-1]};
      trial   = rsh[TOTAL_W-1:0] - TOTAL_W'(count_ff);
      r0      = '0;
      r0.fill_count = 7'(count_ff);

      state_in = state_ff; count_in = count_ff; mode_in = mode_ff; pos_in = pos_ff;
      key_in = key_ff; hold_in = hold_ff; i_in = i_ff; lo_in = lo_ff; hi_in = hi_ff;
      mid_in = mid_ff; sum_in = sum_ff; big_in = big_ff; sml_in = sml_ff;
      dcnt_in = dcnt_ff; quo_in = quo_ff; rem_in = rem_ff; neg_in = neg_ff;
      any_in = any_ff; pend_in = pend_ff; pidx_in = pidx_ff; res_in = res_ff;
      ov_in = ov_ff; olast_in = olast_ff;
      raddr = '0; waddr = '0; we = 1'b0; wdata = key_ff;

      if (ov_ff && rsp_tready) ov_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               mode_in = req_tdata[2:0];
               pos_in  = req_tdata[9:3];
               key_in  = req_tdata[41:10];
               wdata   = req_tdata[41:10];
               res_in  = r0;
               olast_in = 1'b1;
               i_in    = '0;
               unique case (req_tdata[2:0])
                  MODE_APPEND: begin
                     if (fits) begin
                        we = 1'b1; waddr = AW'(count_ff);
                        count_in = count_ff + 1'b1;
                        res_in.ok = 1'b1;
                        res_in.fill_count = 7'(count_ff + 1'b1);
                     end
                     ov_in = 1'b1;
                  end
                  MODE_INSERT: begin
                     if (fits && req_tdata[9:3] <= 7'(count_ff)) begin
                        i_in = (CW+1)'(count_ff);
                        state_in = ST_INS_RD;
                     end else ov_in = 1'b1;
                  end
                  MODE_DELETE: begin
                     if (req_tdata[9:3] < 7'(count_ff)) begin
                        i_in = (CW+1)'(req_tdata[9:3]);
                        raddr = AW'(req_tdata[9:3]);
                        state_in = ST_DEL_RD;
                     end else ov_in = 1'b1;
                  end
                  MODE_LSRCH: begin
                     any_in = 1'b0; pend_in = 1'b0;
                     raddr = '0;
                     if (count_ff == '0) ov_in = 1'b1;
                     else state_in = ST_LS;
                  end
                  MODE_BSRCH: begin
                     lo_in = '0;
                     hi_in = (CW+1)'(count_ff) - 1'b1;
                     if (count_ff == '0) ov_in = 1'b1;
                     else state_in = ST_BS_RD;
                  end
                  MODE_STATS: begin
                     sum_in = '0; big_in = INT_MIN; sml_in = INT_MAX;
                     raddr = '0;
                     if (count_ff == '0) begin
                        res_in.ok = 1'b1;
                        res_in.largest = INT_MIN;
                        res_in.smallest = INT_MAX;
                        ov_in = 1'b1;
                     end else state_in = ST_STAT;
                  end
                  default: ov_in = 1'b1;
               endcase
            end
         end
         // insert: move i-1 to i while i > pos, then write key at pos
         ST_INS_RD: begin
            if (i_ff > (CW+1)'(pos_ff)) begin
               raddr = AW'(i_ff - 1'b1);
               state_in = ST_INS_WR;
            end else begin
               we = 1'b1; waddr = AW'(pos_ff); wdata = key_ff;
               count_in = count_ff + 1'b1;
               res_in.ok = 1'b1;
               res_in.fill_count = 7'(count_ff + 1'b1);
               ov_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_INS_WR: begin
            we = 1'b1; waddr = AW'(i_ff); wdata = rdata_ff;
            i_in = i_ff - 1'b1;
            state_in = ST_INS_RD;
         end
         // delete: first read gives removed word, then move i+1 down to i
         ST_DEL_RD: begin
            if (i_ff == (CW+1)'(pos_ff)) hold_in = rdata_ff;
            if (i_ff + 1'b1 < (CW+1)'(count_ff)) begin
               raddr = AW'(i_ff + 1'b1);
               state_in = ST_DEL_WR;
            end else begin
               we = 1'b1; waddr = AW'(count_ff - 1'b1); wdata = '0;
               count_in = count_ff - 1'b1;
               res_in.ok = 1'b1;
               res_in.removed_value = (i_ff == (CW+1)'(pos_ff)) ? rdata_ff : hold_ff;
               res_in.fill_count = 7'(count_ff - 1'b1);
               ov_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DEL_WR: begin
            we = 1'b1; waddr = AW'(i_ff); wdata = rdata_ff;
            i_in = i_ff + 1'b1;
            state_in = ST_DEL_RD;
         end
         // linear search: one match held back so the final one carries last
         ST_LS: begin
            if (!(ov_ff && !rsp_tready) || !(pend_ff && rdata_ff == key_ff)) begin
               if (rdata_ff == key_ff) begin
                  if (pend_ff) begin
                     res_in = r0; res_in.ok = 1'b1; res_in.found_index = IDX_W'(pidx_ff);
                     olast_in = 1'b0; ov_in = 1'b1;
                  end
                  pend_in = 1'b1; any_in = 1'b1; pidx_in = AW'(i_ff);
               end
               if (i_ff + 1'b1 < (CW+1)'(count_ff)) begin
                  i_in = i_ff + 1'b1;
                  raddr = AW'(i_ff + 1'b1);
               end else state_in = ST_OUT;
            end else raddr = AW'(i_ff);
         end
         ST_OUT: begin
            if (!ov_ff || rsp_tready) begin
               res_in = r0; olast_in = 1'b1; ov_in = 1'b1;
               if (pend_ff) begin
                  res_in.ok = 1'b1; res_in.found_index = IDX_W'(pidx_ff);
               end
               state_in = ST_IDLE;
            end
         end
         ST_BS_RD: begin
            if (lo_ff <= hi_ff) begin
               mid_in = AW'((lo_ff + hi_ff) >>> 1);
               raddr  = AW'((lo_ff + hi_ff) >>> 1);
               state_in = ST_BS_CMP;
            end else begin
               ov_in = 1'b1; state_in = ST_IDLE;
            end
         end
         ST_BS_CMP: begin
            if (rdata_ff == key_ff) begin
               res_in.ok = 1'b1; res_in.found_index = IDX_W'(mid_ff);
               ov_in = 1'b1; state_in = ST_IDLE;
            end else begin
               if (rdata_ff < key_ff) lo_in = (CW+1)'(mid_ff) + 1'b1;
               else hi_in = (CW+1)'(mid_ff) - 1'b1;
               state_in = ST_BS_RD;
            end
         end
         ST_STAT: begin
            sum_in = sum_ff + TOTAL_W'(rdata_ff);
            if (rdata_ff > big_ff) big_in = rdata_ff;
            if (rdata_ff < sml_ff) sml_in = rdata_ff;
            if (i_ff + 1'b1 < (CW+1)'(count_ff)) begin
               i_in = i_ff + 1'b1;
               raddr = AW'(i_ff + 1'b1);
            end else begin
               state_in = ST_DIV;
               dcnt_in = '0;
            end
         end
         // restoring division of |sum| by count, one quotient bit a cycle
         ST_DIV: begin
            if (dcnt_ff == '0) begin
               neg_in = sum_ff[TOTAL_W-1];
               quo_in = mag; rem_in = '0;
               dcnt_in = 6'd1;
            end else if (dcnt_ff <= 6'(TOTAL_W)) begin
               if (rsh >= (TOTAL_W+1)'(count_ff)) begin
                  rem_in = trial;
                  quo_in = {quo_ff[TOTAL_W-2:0], 1'b1};
               end else begin
                  rem_in = rsh[TOTAL_W-1:0];
                  quo_in = {quo_ff[TOTAL_W-2:0], 1'b0};
               end
               dcnt_in = dcnt_ff + 1'b1;
            end else begin
               res_in.ok = 1'b1;
               res_in.total = sum_ff;
               res_in.average = neg_ff ? -WORD_W'(quo_ff) : WORD_W'(quo_ff);
               res_in.largest = big_ff;
               res_in.smallest = sml_ff;
               ov_in = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`include "ordered_array_table_engine_unit_defines.svh"
   `OATE_ASSERT(a_count_range, clock, reset, count_ff <= CW'(DEPTH), "count above depth")
   `OATE_ASSERT(a_idle_ready, clock, reset,
      !req_tready || (state_ff == ST_IDLE), "ready outside idle")
   `OATE_ASSERT_NEXT(a_out_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
endmodule
`default_nettype wire

FILE: bench/ordered_array_table_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// ordered_array_table_engine_unit_tb
// Self-checking bench for the ordered array table engine. A behavioral copy
// of the word store predicts every result transaction. Named tests cover the
// empty store, field extremes, capacity limits, sorted binary search and a
// long random mix. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ordered_array_table_engine_unit_tb;
   import oate_pkg::*;

   localparam int DEPTH = 64;
   localparam logic [2:0] MODE_BAD6 = 3'd6;
   localparam logic [2:0] MODE_BAD7 = 3'd7;

   typedef struct {
      result_type fields;
      logic       last;
   } entry_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [6:0]   csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [183:0] rsp_tdata;
   logic         rsp_tlast;

   // shadow of the block state
   logic signed [31:0] shadow_words [DEPTH];
   int                 shadow_count;
   int                 shadow_cap;

   entry_result_type pending_results [$];
   int            err_count;
   bit            ready_free;   // no stalls on the result side when set
   int            stall_left = 0;

   ordered_array_table_engine_unit uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 15);
      if (r < 8) return 0;
      if (r < 14) return $urandom_range(1, 3);
      if (r < 15) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      err_count++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   function automatic void push_result(input logic ok, input int idx,
                                       input logic signed [31:0] removed,
                                       input longint sum, input longint avg,
                                       input logic signed [31:0] big,
                                       input logic signed [31:0] tiny, input logic fin);
      entry_result_type e;
      e.fields.ok            = ok;
      e.fields.found_index   = idx[5:0];
      e.fields.removed_value = removed;
      e.fields.total         = sum[38:0];
      e.fields.average       = avg[31:0];
      e.fields.largest       = big;
      e.fields.smallest      = tiny;
      e.fields.fill_count    = shadow_count[6:0];
      e.last                 = fin;
      pending_results.push_back(e);
   endfunction

   // apply one operation to the shadow store and queue its results
   function automatic void predict_operation(input logic [2:0] mode, input int pos,
                                             input logic signed [31:0] word);
      int cap;
      int lo, hi, mid, last_hit;
      longint sum, big, tiny;
      logic signed [31:0] removed;
      bit hit;
      cap = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
      case (mode)
         MODE_APPEND: begin
            if (shadow_count < cap) begin
               shadow_words[shadow_count] = word;
               shadow_count++;
               push_result(1, 0, 0, 0, 0, 0, 0, 1);
            end else begin
               push_result(0, 0, 0, 0, 0, 0, 0, 1);
            end
         end
         MODE_INSERT: begin
            if (pos <= shadow_count && shadow_count < cap) begin
               for (int i = shadow_count; i > pos; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[pos] = word;
               shadow_count++;
               push_result(1, 0, 0, 0, 0, 0, 0, 1);
            end else begin
               push_result(0, 0, 0, 0, 0, 0, 0, 1);
            end
         end
         MODE_DELETE: begin
            if (pos < shadow_count) begin
               removed = shadow_words[pos];
               for (int i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
               shadow_count--;
               shadow_words[shadow_count] = 0;
               push_result(1, 0, removed, 0, 0, 0, 0, 1);
            end else begin
               push_result(0, 0, 0, 0, 0, 0, 0, 1);
            end
         end
         MODE_LSRCH: begin
            hit = 0;
            last_hit = 0;
            for (int i = 0; i < shadow_count; i++)
               if (shadow_words[i] == word) begin
                  hit = 1;
                  last_hit = i;
               end
            if (!hit) push_result(0, 0, 0, 0, 0, 0, 0, 1);
            for (int i = 0; i < shadow_count; i++)
               if (shadow_words[i] == word) push_result(1, i, 0, 0, 0, 0, 0, i == last_hit);
         end
         MODE_BSRCH: begin
            lo = 0;
            hi = shadow_count - 1;
            hit = 0;
            while (lo <= hi && !hit) begin
               mid = (lo + hi) / 2;
               if (shadow_words[mid] == word) hit = 1;
               else if (shadow_words[mid] < word) lo = mid + 1;
               else hi = mid - 1;
            end
            if (hit) push_result(1, mid, 0, 0, 0, 0, 0, 1);
            else push_result(0, 0, 0, 0, 0, 0, 0, 1);
         end
         MODE_STATS: begin
            sum = 0;
            big = INT_MIN;
            tiny = INT_MAX;
            for (int i = 0; i < shadow_count; i++) begin
               sum += shadow_words[i];
               if (shadow_words[i] > big) big = shadow_words[i];
               if (shadow_words[i] < tiny) tiny = shadow_words[i];
            end
            push_result(1, 0, 0, sum, (shadow_count > 0) ? sum / shadow_count : 0,
                        big[31:0], tiny[31:0], 1);
         end
         default: push_result(0, 0, 0, 0, 0, 0, 0, 1);
      endcase
   endfunction

   task automatic send_op(input logic [2:0] mode, input int pos, input logic signed [31:0] word);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, word, pos[6:0], mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_operation(mode, pos, word);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic set_capacity(input int cap);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= cap[6:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow_cap = cap;
   endtask

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return INT_MIN;
         1: return INT_MAX;
         2: return -1;
         3, 4: return $urandom_range(0, 5);
         default: return $urandom;
      endcase
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      int r;
      if (ready_free) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         r = $urandom_range(0, 3);
         rsp_tready <= (r != 0);
         stall_left <= (r != 0) ? $urandom_range(0, 6) : pick_gap();
      end
   end

   // result checker
   always @(posedge clock) begin
      entry_result_type want;
      result_type    got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[180:0];
         if (pending_results.size() == 0) begin
            report("unexpected transaction", rsp_tdata[63:0], 0);
         end else begin
            want = pending_results.pop_front();
            if (got.ok !== want.fields.ok) report("ok", got.ok, want.fields.ok);
            if (got.found_index !== want.fields.found_index)
               report("found_index", got.found_index, want.fields.found_index);
            if (got.removed_value !== want.fields.removed_value)
               report("removed_value", got.removed_value, want.fields.removed_value);
            if (got.total !== want.fields.total) report("total", got.total, want.fields.total);
            if (got.average !== want.fields.average)
               report("average", got.average, want.fields.average);
            if (got.largest !== want.fields.largest)
               report("largest", got.largest, want.fields.largest);
            if (got.smallest !== want.fields.smallest)
               report("smallest", got.smallest, want.fields.smallest);
            if (got.fill_count !== want.fields.fill_count)
               report("fill_count", got.fill_count, want.fields.fill_count);
            if (rsp_tlast !== want.last) report("tlast", rsp_tlast, want.last);
         end
      end
   end

   task automatic test_empty_store();
      send_op(MODE_STATS, 0, 0);
      send_op(MODE_LSRCH, 0, 0);
      send_op(MODE_BSRCH, 0, -1);
      send_op(MODE_DELETE, 0, 0);
      send_op(MODE_INSERT, 1, 5);
   endtask

   task automatic test_field_extremes();
      send_op(MODE_APPEND, 0, INT_MIN);
      send_op(MODE_APPEND, 127, INT_MAX);
      send_op(MODE_INSERT, 0, -1);
      send_op(MODE_INSERT, 3, 0);
      send_op(MODE_INSERT, 127, 7);
      send_op(MODE_APPEND, 0, -1);
      send_op(MODE_LSRCH, 0, -1);
      send_op(MODE_STATS, 0, 0);
      send_op(MODE_BAD6, 127, INT_MAX);
      send_op(MODE_BAD7, 5, INT_MIN);
      send_op(MODE_DELETE, 4, 0);
      send_op(MODE_DELETE, 127, 0);
      send_op(MODE_DELETE, 0, 0);
      send_op(MODE_STATS, 0, 0);
   endtask

   task automatic test_capacity_limits();
      set_capacity(2);   // below the current fill count: words stay
      send_op(MODE_APPEND, 0, 9);
      send_op(MODE_INSERT, 0, 9);
      send_op(MODE_STATS, 0, 0);
      set_capacity(0);
      send_op(MODE_APPEND, 0, 1);
      set_capacity(127);
      send_op(MODE_APPEND, 0, 1);
      set_capacity(64);
   endtask

   task automatic test_sorted_search();
      int base;
      while (shadow_count > 0) send_op(MODE_DELETE, 0, 0);
      base = $urandom_range(0, 1000) - 500;
      for (int i = 0; i < 24; i++) send_op(MODE_APPEND, 0, base + 3 * i);
      for (int i = 0; i < 20; i++)
         send_op(MODE_BSRCH, 0, base + $urandom_range(0, 75) - 2);
      // full store of one value: linear search hits every entry
      while (shadow_count > 0) send_op(MODE_DELETE, shadow_count - 1, 0);
      ready_free = 1'b1;
      for (int i = 0; i < DEPTH; i++) send_op(MODE_APPEND, 0, 4);
      send_op(MODE_APPEND, 0, 4);
      send_op(MODE_LSRCH, 0, 4);
      send_op(MODE_BSRCH, 0, 4);
      send_op(MODE_STATS, 0, 0);
      drain();
      ready_free = 1'b0;
      while (shadow_count > 8) send_op(MODE_DELETE, $urandom_range(0, shadow_count - 1), 0);
   endtask

   task automatic test_random_mix(input int n_ops);
      logic [2:0] mode;
      int pos, r;
      for (int k = 0; k < n_ops; k++) begin
         if (k % 120 == 119) set_capacity($urandom_range(1, 64));
         if (k == n_ops / 2) ready_free = 1'b1;
         if (k == n_ops / 2 + 40) ready_free = 1'b0;
         r = $urandom_range(0, 99);
         if (r < 22) mode = MODE_APPEND;
         else if (r < 40) mode = MODE_INSERT;
         else if (r < 62) mode = MODE_DELETE;
         else if (r < 78) mode = MODE_LSRCH;
         else if (r < 88) mode = MODE_BSRCH;
         else if (r < 97) mode = MODE_STATS;
         else mode = 3'($urandom_range(6, 7));
         if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 127);
         else pos = $urandom_range(0, shadow_count + 1);
         send_op(mode, pos, pick_word());
      end
   endtask

   initial begin
      err_count  = 0;
      ready_free = 1'b0;
      shadow_count = 0;
      shadow_cap = 64;
      for (int i = 0; i < DEPTH; i++) shadow_words[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_store();
      test_field_extremes();
      test_capacity_limits();
      test_sorted_search();
      test_random_mix(190);
      set_capacity(64);
      drain();
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/oate_pkg.sv
rtl/core/ordered_array_table_engine_unit.sv
bench/ordered_array_table_engine_unit_tb.sv
